// File: src/opd_pkg.sv
// Shared types and codes for the OpenPGP packet deframer.
// Holds the input and result word structs and the result event codes.
// No dependencies.
`timescale 1ns / 1ps

package opd_pkg;

    localparam int unsigned CfgAddrWidth = 3;
    localparam logic [31:0] MaxBodyLengthReset = 32'd1048576;

    // Result event codes.
    localparam logic [3:0] EV_HEADER   = 4'd0;
    localparam logic [3:0] EV_BODY     = 4'd1;
    localparam logic [3:0] EV_EMPTY    = 4'd2;
    localparam logic [3:0] EV_SKIP     = 4'd3;
    localparam logic [3:0] EV_BADTAG   = 4'd4;
    localparam logic [3:0] EV_TRUNC    = 4'd5;
    localparam logic [3:0] EV_END      = 4'd6;
    localparam logic [3:0] EV_DISCARD  = 4'd7;
    localparam logic [3:0] EV_OVERSIZE = 4'd8;

    // Length kinds.
    localparam logic [2:0] LK_ONE     = 3'd0;
    localparam logic [2:0] LK_TWO     = 3'd1;
    localparam logic [2:0] LK_FOUR    = 3'd2;
    localparam logic [2:0] LK_PARTIAL = 3'd3;
    localparam logic [2:0] LK_INDET   = 3'd4;

    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } opd_in_t;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [5:0]  pkt_type;
        logic        new_format;
        logic [2:0]  length_kind;
        logic [31:0] part_length;
        logic [7:0]  body_byte;
        logic        first_of_packet;
        logic        last_of_part;
        logic        last_of_packet;
    } opd_out_t;

endpackage

// File: src/openpgp_packet_deframer_core.sv
// OpenPGP packet deframer, top level.
// Depends on opd_pkg for the word structs, event codes and length kinds.
`timescale 1ns / 1ps

// The block takes an OpenPGP byte stream on the input channel, one word per
// stream byte, plus one word that marks end of input. For every accepted
// input word it delivers exactly one result word on the output channel: a
// header byte, a body byte tagged with packet type and part length, or a
// status event such as an empty part, a skipped oversize byte, a bad tag, a
// truncated stream or a clean end.
// A word is accepted at a rising edge where in_valid is high and in_stall is
// low; a result is taken where out_valid is high and out_stall is low.
// The result of a word accepted at one edge is registered in the output
// register, or in the skid register while the receiver stalls. Throughput is
// one word per cycle while in_stall is low; the parsing state updates on
// every accepted word, so nothing limits the rate but the receiver.
// When the receiver stalls, the pending result holds in the output register
// and one more input word can still be taken into a skid register; only
// then is in_stall raised, so in_stall is driven from a register.
// Reset clears the parser to the stream-start state, empties both result
// registers and sets max_body_length to 1048576. The APB port holds that
// one register at address 0; it is meant to be written only while idle.
module openpgp_packet_deframer_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  opd_pkg::opd_in_t                       in_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output opd_pkg::opd_out_t                      out_data,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [opd_pkg::CfgAddrWidth-1:0]       paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    // Parser phases.
    localparam logic [2:0] PH_TAG    = 3'd0;
    localparam logic [2:0] PH_NEWLEN = 3'd1;
    localparam logic [2:0] PH_LEN    = 3'd2;
    localparam logic [2:0] PH_BODY   = 3'd3;
    localparam logic [2:0] PH_INDET  = 3'd4;

    logic [31:0] max_body_length_reg;

    logic [2:0]  phase_reg, phase_next;
    logic [5:0]  tag_type_reg, tag_type_next;
    logic        tag_is_new_reg, tag_is_new_next;
    logic [2:0]  kind_reg, kind_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  len_left_reg, len_left_next;
    logic [31:0] body_left_reg, body_left_next;
    logic        partial_reg, partial_next;
    logic        started_reg, started_next;
    logic        skipping_reg, skipping_next;
    logic        error_reg, error_next;

    opd_pkg::opd_out_t result;
    opd_pkg::opd_out_t main_reg;
    opd_pkg::opd_out_t skid_reg;
    logic              main_valid_reg;
    logic              skid_valid_reg;

    logic push;
    logic pop;
    logic cfg_write;

    // Configuration port: a single register, decoded on paddr[2] alone.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? max_body_length_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_body_length_reg <= opd_pkg::MaxBodyLengthReset;
        end
        else if (cfg_write)
        begin
            max_body_length_reg <= pwdata;
        end
    end

    assign push = in_valid && !in_stall;
    assign pop  = main_valid_reg && !out_stall;

    // Parser: next state and the result for the incoming word.
    always_comb
    begin
        logic        fin_en;
        logic [31:0] fin_len;
        logic [31:0] acc_sh;
        logic [2:0]  left_dec;
        logic [31:0] body_dec;
        logic        lp;
        logic [7:0]  b;

        phase_next      = phase_reg;
        tag_type_next   = tag_type_reg;
        tag_is_new_next = tag_is_new_reg;
        kind_next       = kind_reg;
        acc_next        = acc_reg;
        len_left_next   = len_left_reg;
        body_left_next  = body_left_reg;
        partial_next    = partial_reg;
        started_next    = started_reg;
        skipping_next   = skipping_reg;
        error_next      = error_reg;
        result          = '0;
        fin_en          = 1'b0;
        fin_len         = 32'd0;
        b               = in_data.data_byte;
        acc_sh          = {acc_reg[23:0], b};
        left_dec        = (len_left_reg != 3'd0) ? (len_left_reg - 3'd1) : 3'd0;
        body_dec        = (body_left_reg != 32'd0) ? (body_left_reg - 32'd1) : 32'd0;
        lp              = (body_dec == 32'd0);

        if (in_data.action)
        begin
            // End of input: report from the current state, then restart.
            if (error_reg)
            begin
                result.event_res = opd_pkg::EV_DISCARD;
            end
            else if (phase_reg == PH_TAG)
            begin
                result.event_res = opd_pkg::EV_END;
            end
            else if (phase_reg == PH_INDET)
            begin
                result.event_res      = opd_pkg::EV_END;
                result.pkt_type       = tag_type_reg;
                result.new_format     = tag_is_new_reg;
                result.length_kind    = kind_reg;
                result.last_of_part   = 1'b1;
                result.last_of_packet = 1'b1;
            end
            else
            begin
                result.event_res   = opd_pkg::EV_TRUNC;
                result.pkt_type    = tag_type_reg;
                result.new_format  = tag_is_new_reg;
                result.length_kind = kind_reg;
                result.part_length = (phase_reg == PH_BODY) ? acc_reg : 32'd0;
            end
            phase_next      = PH_TAG;
            tag_type_next   = 6'd0;
            tag_is_new_next = 1'b0;
            kind_next       = 3'd0;
            acc_next        = 32'd0;
            len_left_next   = 3'd0;
            body_left_next  = 32'd0;
            partial_next    = 1'b0;
            started_next    = 1'b0;
            skipping_next   = 1'b0;
            error_next      = 1'b0;
        end
        else if (error_reg)
        begin
            result.event_res = opd_pkg::EV_DISCARD;
        end
        else
        begin
            case (phase_reg)
                PH_TAG:
                begin
                    if (!b[7])
                    begin
                        error_next       = 1'b1;
                        result.event_res = opd_pkg::EV_BADTAG;
                    end
                    else
                    begin
                        started_next   = 1'b0;
                        skipping_next  = 1'b0;
                        partial_next   = 1'b0;
                        acc_next       = 32'd0;
                        body_left_next = 32'd0;
                        if (b[6])
                        begin
                            tag_is_new_next = 1'b1;
                            tag_type_next   = b[5:0];
                            kind_next       = opd_pkg::LK_ONE;
                            phase_next      = PH_NEWLEN;
                        end
                        else
                        begin
                            tag_is_new_next = 1'b0;
                            tag_type_next   = {2'b00, b[5:2]};
                            if (b[1:0] == 2'd3)
                            begin
                                kind_next  = opd_pkg::LK_INDET;
                                phase_next = PH_INDET;
                            end
                            else
                            begin
                                kind_next     = {1'b0, b[1:0]};
                                len_left_next = (b[1:0] == 2'd0) ? 3'd1 :
                                                (b[1:0] == 2'd1) ? 3'd2 : 3'd4;
                                phase_next    = PH_LEN;
                            end
                        end
                        result.event_res = opd_pkg::EV_HEADER;
                    end
                end

                PH_NEWLEN:
                begin
                    partial_next = 1'b0;
                    if (b < 8'hc0)
                    begin
                        kind_next = opd_pkg::LK_ONE;
                        fin_en    = 1'b1;
                        fin_len   = {24'd0, b};
                    end
                    else if (b <= 8'hdf)
                    begin
                        kind_next        = opd_pkg::LK_TWO;
                        acc_next         = {27'd0, b[4:0]};
                        len_left_next    = 3'd1;
                        phase_next       = PH_LEN;
                        result.event_res = opd_pkg::EV_HEADER;
                    end
                    else if (b <= 8'hfe)
                    begin
                        // Partial part: length is a power of two.
                        kind_next    = opd_pkg::LK_PARTIAL;
                        partial_next = 1'b1;
                        fin_en       = 1'b1;
                        fin_len      = 32'd1 << b[4:0];
                    end
                    else
                    begin
                        kind_next        = opd_pkg::LK_FOUR;
                        acc_next         = 32'd0;
                        len_left_next    = 3'd4;
                        phase_next       = PH_LEN;
                        result.event_res = opd_pkg::EV_HEADER;
                    end
                end

                PH_LEN:
                begin
                    acc_next      = acc_sh;
                    len_left_next = left_dec;
                    if (left_dec == 3'd0)
                    begin
                        fin_en  = 1'b1;
                        fin_len = (tag_is_new_reg && kind_reg == opd_pkg::LK_TWO) ?
                                  (acc_sh + 32'd192) : acc_sh;
                    end
                    else
                    begin
                        result.event_res = opd_pkg::EV_HEADER;
                    end
                end

                PH_BODY:
                begin
                    body_left_next     = body_dec;
                    result.part_length = acc_reg;
                    result.last_of_part = lp;
                    if (skipping_reg)
                    begin
                        result.event_res      = opd_pkg::EV_SKIP;
                        result.last_of_packet = lp;
                        if (lp)
                        begin
                            phase_next = PH_TAG;
                        end
                    end
                    else
                    begin
                        result.event_res       = opd_pkg::EV_BODY;
                        result.body_byte       = b;
                        result.first_of_packet = !started_reg;
                        result.last_of_packet  = lp && !partial_reg;
                        started_next           = 1'b1;
                        if (lp)
                        begin
                            phase_next = partial_reg ? PH_NEWLEN : PH_TAG;
                        end
                    end
                end

                default:
                begin
                    // Indeterminate body runs until end of input.
                    result.event_res       = opd_pkg::EV_BODY;
                    result.body_byte       = b;
                    result.first_of_packet = !started_reg;
                    started_next           = 1'b1;
                    phase_next             = PH_INDET;
                end
            endcase

            // A completed length decides between empty, oversize and body.
            if (fin_en)
            begin
                acc_next       = fin_len;
                body_left_next = fin_len;
                if (fin_len == 32'd0)
                begin
                    phase_next            = PH_TAG;
                    result.event_res      = opd_pkg::EV_EMPTY;
                    result.last_of_part   = 1'b1;
                    result.last_of_packet = 1'b1;
                end
                else if ((fin_len > max_body_length_reg) && (partial_next || started_reg))
                begin
                    error_next         = 1'b1;
                    result.event_res   = opd_pkg::EV_OVERSIZE;
                    result.part_length = fin_len;
                end
                else
                begin
                    if (fin_len > max_body_length_reg)
                    begin
                        skipping_next = 1'b1;
                    end
                    phase_next         = PH_BODY;
                    result.event_res   = opd_pkg::EV_HEADER;
                    result.part_length = fin_len;
                end
            end

            // Tag fields go out on every data-path result but the tag-less ones.
            if (result.event_res != opd_pkg::EV_BADTAG)
            begin
                result.pkt_type    = tag_type_next;
                result.new_format  = tag_is_new_next;
                result.length_kind = kind_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_TAG;
            tag_type_reg   <= 6'd0;
            tag_is_new_reg <= 1'b0;
            kind_reg       <= 3'd0;
            acc_reg        <= 32'd0;
            len_left_reg   <= 3'd0;
            body_left_reg  <= 32'd0;
            partial_reg    <= 1'b0;
            started_reg    <= 1'b0;
            skipping_reg   <= 1'b0;
            error_reg      <= 1'b0;
        end
        else if (push)
        begin
            phase_reg      <= phase_next;
            tag_type_reg   <= tag_type_next;
            tag_is_new_reg <= tag_is_new_next;
            kind_reg       <= kind_next;
            acc_reg        <= acc_next;
            len_left_reg   <= len_left_next;
            body_left_reg  <= body_left_next;
            partial_reg    <= partial_next;
            started_reg    <= started_next;
            skipping_reg   <= skipping_next;
            error_reg      <= error_next;
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                main_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (main_valid_reg && !pop)
            begin
                skid_reg <= result;
            end
            else
            begin
                main_reg <= result;
            end
        end
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule
